// ===== hdl/frs_pkg.sv =====
package frs_pkg;

  localparam int RATE_W      = 18;
  localparam int TARGET_W    = 8;
  localparam int BAND_W      = 15;
  localparam int CFG_SCALE_W = 17;
  localparam int CFG_DATA_W  = 18;
  localparam int CFG_IDX_W   = 3;
  localparam int TQ_W        = 16;
  localparam int ACT_W       = 2;
  localparam int IN_W        = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PANIC  = 3'd4;

  localparam logic [ACT_W-1:0] ACT_HOLD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FLOOR  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ADJUST = 2'd2;

  localparam logic [TARGET_W-1:0]    TARGET_RST = 8'd90;
  localparam logic [BAND_W-1:0]      BAND_RST   = 15'd256;
  localparam logic [CFG_SCALE_W-1:0] WEIGHT_RST = 17'd6554;
  localparam logic [CFG_SCALE_W-1:0] FLOOR_RST  = 17'd3277;
  localparam logic [RATE_W-1:0]      PANIC_RST  = 18'd11520;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_RATE,
    ST_START,
    ST_ROOT,
    ST_BLEND,
    ST_CLAMP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RP_IDLE,
    RP_DIV,
    RP_SQRT
  } root_phase_t;

endpackage

// ===== hdl/frame_rate_resolution_scaler_core.sv =====
// Frame-rate driven resolution scaler. Give it one item per rendered frame
// (instantaneous and smoothed rate, Q10.8) and it returns the render scale
// (FRAC_BITS fraction bits, 1.0 = 2^FRAC_BITS) with an action code: 0 held,
// 1 emergency drop to the floor, 2 adjusted. One item is in work at a time.
// An emergency or held item goes from ST_IDLE straight to ST_DONE, where it
// is loaded into the output register once that is free. An adjusted item
// passes ST_SQUARE, ST_RATE, ST_START, ST_ROOT, ST_BLEND and ST_CLAMP to
// ST_DONE, using the bit-serial shift-add multiplier (2*(FRAC_BITS+1)+18
// steps), the restoring divider in frs_root (one quotient bit per cycle,
// 2*FRAC_BITS+20 steps) and its square-root pass (one result bit per cycle,
// FRAC_BITS+10 steps). A finished result waits in the output register while
// the next item is taken; while the output is held off, an item stays in
// ST_DONE and no new item is taken. Configuration writes take effect at once.
module frame_rate_resolution_scaler_core #(
  parameter int FRAC_BITS = 16,
  localparam int SW = FRAC_BITS + 1,
  localparam int OUT_W = ((SW + frs_pkg::ACT_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [frs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [frs_pkg::IN_W-1:0]       s_tdata,  // instant_rate, smoothed_rate
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [OUT_W-1:0]               m_tdata   // new_scale, action
);

  localparam int RW     = frs_pkg::RATE_W;
  localparam int NUM_W  = 2 * SW + 17;
  localparam int SQ_W   = NUM_W + NUM_W % 2;
  localparam int ROOT_W = SQ_W / 2;
  localparam int MW     = (SW > RW) ? SW : RW;
  localparam int LW     = (SW > frs_pkg::CFG_SCALE_W) ? SW : frs_pkg::CFG_SCALE_W;
  localparam int CNTW   = $clog2(MW);
  localparam int BW     = SW + ROOT_W + 1;
  localparam int BV_W   = BW - FRAC_BITS;
  localparam logic [SW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SW-1:0] HALF = ONE >> 1;

  frs_pkg::state_t state, state_next;

  logic [frs_pkg::TARGET_W-1:0]    target_rate;
  logic [frs_pkg::BAND_W-1:0]      hold_band;
  logic [frs_pkg::CFG_SCALE_W-1:0] blend_weight;
  logic [frs_pkg::CFG_SCALE_W-1:0] floor_scale;
  logic [RW-1:0]                   panic_rate;

  logic [SW-1:0]            current_scale;
  logic [SW-1:0]            res_scale;
  logic [frs_pkg::ACT_W-1:0] res_action;
  logic [RW-1:0]            avg;
  logic [CNTW-1:0]          cnt;
  logic [MW-1:0]            mplier;
  logic [2*SW-2:0]          mcand;
  logic [NUM_W-1:0]         acc;
  logic signed [BW-1:0]     bacc;

  logic [RW-1:0]                instant_rate;
  logic [RW-1:0]                smoothed_rate;
  logic [frs_pkg::TARGET_W-1:0] tgt;
  logic [frs_pkg::TQ_W-1:0]     tq;
  logic [RW-1:0]                tqx;
  logic [RW-1:0]                diff;
  logic                         emergency;
  logic                         hold;
  logic [LW-1:0]                floor_x;
  logic [LW-1:0]                weight_x;
  logic [SW-1:0]                lo;
  logic [SW-1:0]                w_eff;
  logic [NUM_W-1:0]             acc_step;
  logic [ROOT_W-1:0]            root_q;
  logic                         root_done;
  logic                         root_start;
  logic signed [ROOT_W:0]       dif;
  logic signed [BW-1:0]         bacc_step;
  logic signed [BW-1:0]         bsum;
  logic [BV_W-1:0]              bval;
  logic [SW-1:0]                bclamp;
  logic                         out_load;

  assign instant_rate  = s_tdata[RW-1:0];
  assign smoothed_rate = s_tdata[2*RW-1:RW];

  assign tgt       = (target_rate == '0) ? frs_pkg::TARGET_W'(1) : target_rate;
  assign tq        = {tgt, 8'h00};
  assign tqx       = RW'(tq);
  assign diff      = (smoothed_rate >= tqx) ? smoothed_rate - tqx : tqx - smoothed_rate;
  assign emergency = instant_rate < panic_rate;
  assign hold      = diff < RW'(hold_band);

  assign floor_x  = LW'(floor_scale);
  assign weight_x = LW'(blend_weight);
  assign lo       = (floor_scale == '0) ? SW'(1) :
                    (floor_x > LW'(ONE)) ? ONE : floor_x[SW-1:0];
  assign w_eff    = (weight_x > LW'(ONE)) ? ONE : weight_x[SW-1:0];

  assign acc_step = (acc << 1) + (mplier[MW-1] ? NUM_W'(mcand) : '0);

  assign dif       = $signed({1'b0, root_q}) - $signed((ROOT_W + 1)'(current_scale));
  assign bacc_step = (bacc <<< 1) + (mplier[MW-1] ? BW'(dif) : BW'(0));
  assign bsum      = bacc + $signed(BW'(current_scale) << FRAC_BITS) + $signed(BW'(HALF));
  assign bval      = bsum[BW-1:FRAC_BITS];
  assign bclamp    = (bval < BV_W'(lo)) ? lo :
                     (bval > BV_W'(ONE)) ? ONE : bval[SW-1:0];

  frs_root #(
    .NUM_W(NUM_W)
  ) u_root (
    .clk  (clk),
    .rst  (rst),
    .start(root_start),
    .num  (acc),
    .den  (tq),
    .root (root_q),
    .done (root_done)
  );

  always_comb begin
    state_next = state;
    case (state)
      frs_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (emergency || hold) ? frs_pkg::ST_DONE : frs_pkg::ST_SQUARE;
        end
      end
      frs_pkg::ST_SQUARE: begin
        if (cnt == '0) state_next = frs_pkg::ST_RATE;
      end
      frs_pkg::ST_RATE: begin
        if (cnt == '0) state_next = frs_pkg::ST_START;
      end
      frs_pkg::ST_START: state_next = frs_pkg::ST_ROOT;
      frs_pkg::ST_ROOT: begin
        if (root_done) state_next = frs_pkg::ST_BLEND;
      end
      frs_pkg::ST_BLEND: begin
        if (cnt == '0) state_next = frs_pkg::ST_CLAMP;
      end
      frs_pkg::ST_CLAMP: state_next = frs_pkg::ST_DONE;
      frs_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = frs_pkg::ST_IDLE;
      end
      default: state_next = frs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    root_start = 1'b0;
    out_load   = 1'b0;
    case (state)
      frs_pkg::ST_IDLE:  s_tready   = 1'b1;
      frs_pkg::ST_START: root_start = 1'b1;
      frs_pkg::ST_DONE:  out_load   = !m_tvalid || m_tready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= frs_pkg::ST_IDLE;
      m_tvalid      <= 1'b0;
      current_scale <= ONE;
      target_rate   <= frs_pkg::TARGET_RST;
      hold_band     <= frs_pkg::BAND_RST;
      blend_weight  <= frs_pkg::WEIGHT_RST;
      floor_scale   <= frs_pkg::FLOOR_RST;
      panic_rate    <= frs_pkg::PANIC_RST;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        case (cfg_index)
          frs_pkg::CFG_TARGET: target_rate  <= cfg_data[frs_pkg::TARGET_W-1:0];
          frs_pkg::CFG_BAND:   hold_band    <= cfg_data[frs_pkg::BAND_W-1:0];
          frs_pkg::CFG_WEIGHT: blend_weight <= cfg_data[frs_pkg::CFG_SCALE_W-1:0];
          frs_pkg::CFG_FLOOR:  floor_scale  <= cfg_data[frs_pkg::CFG_SCALE_W-1:0];
          frs_pkg::CFG_PANIC:  panic_rate   <= cfg_data[RW-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        m_tvalid      <= 1'b1;
        current_scale <= res_scale;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_W'({res_action, res_scale});
    end
    case (state)
      frs_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          avg    <= smoothed_rate;
          acc    <= '0;
          mcand  <= (2 * SW - 1)'(current_scale);
          mplier <= MW'(current_scale) << (MW - SW);
          cnt    <= CNTW'(SW - 1);
          if (emergency) begin
            res_scale  <= lo;
            res_action <= frs_pkg::ACT_FLOOR;
          end else begin
            res_scale  <= current_scale;
            res_action <= frs_pkg::ACT_HOLD;
          end
        end
      end
      frs_pkg::ST_SQUARE: begin
        if (cnt == '0) begin
          mcand  <= acc_step[2*SW-2:0];
          acc    <= '0;
          mplier <= MW'(avg) << (MW - RW);
          cnt    <= CNTW'(RW - 1);
        end else begin
          acc    <= acc_step;
          mplier <= mplier << 1;
          cnt    <= cnt - 1'b1;
        end
      end
      frs_pkg::ST_RATE: begin
        acc    <= acc_step;
        mplier <= mplier << 1;
        cnt    <= cnt - 1'b1;
      end
      frs_pkg::ST_ROOT: begin
        bacc   <= '0;
        mplier <= MW'(w_eff) << (MW - SW);
        cnt    <= CNTW'(SW - 1);
      end
      frs_pkg::ST_BLEND: begin
        bacc   <= bacc_step;
        mplier <= mplier << 1;
        cnt    <= cnt - 1'b1;
      end
      frs_pkg::ST_CLAMP: begin
        res_scale  <= bclamp;
        res_action <= frs_pkg::ACT_ADJUST;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/frs_root.sv =====
module frs_root #(
  parameter int NUM_W = 51,
  localparam int SQ_W = NUM_W + NUM_W % 2,
  localparam int ROOT_W = SQ_W / 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NUM_W-1:0]          num,
  input  logic [frs_pkg::TQ_W-1:0]  den,
  output logic [ROOT_W-1:0]         root,
  output logic                      done
);

  localparam int CW   = $clog2(SQ_W + 1);
  localparam int RS_W = ROOT_W + 2;
  localparam int DW   = frs_pkg::TQ_W;

  frs_pkg::root_phase_t phase, phase_next;

  logic [SQ_W-1:0] q;
  logic [DW-1:0]   rem_d;
  logic [RS_W-1:0] rem_s;
  logic [CW-1:0]   cnt;

  logic [DW:0]     dt;
  logic            dge;
  logic [DW:0]     ddiff;
  logic [RS_W+1:0] st;
  logic [RS_W+1:0] trial;
  logic [RS_W+1:0] sdiff;
  logic            sge;

  assign dt    = {rem_d, q[SQ_W-1]};
  assign dge   = dt >= {1'b0, den};
  assign ddiff = dt - {1'b0, den};
  assign st    = {rem_s, q[SQ_W-1:SQ_W-2]};
  assign trial = (RS_W + 2)'({root, 2'b01});
  assign sge   = st >= trial;
  assign sdiff = st - trial;

  always_comb begin
    phase_next = phase;
    case (phase)
      frs_pkg::RP_IDLE: begin
        if (start) phase_next = frs_pkg::RP_DIV;
      end
      frs_pkg::RP_DIV: begin
        if (cnt == '0) phase_next = frs_pkg::RP_SQRT;
      end
      frs_pkg::RP_SQRT: begin
        if (cnt == '0) phase_next = frs_pkg::RP_IDLE;
      end
      default: phase_next = frs_pkg::RP_IDLE;
    endcase
  end

  always_comb begin
    case (phase)
      frs_pkg::RP_SQRT: done = (cnt == '0);
      default:          done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= frs_pkg::RP_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      frs_pkg::RP_IDLE: begin
        if (start) begin
          q     <= SQ_W'(num);
          rem_d <= '0;
          cnt   <= CW'(SQ_W - 1);
        end
      end
      frs_pkg::RP_DIV: begin
        q     <= {q[SQ_W-2:0], dge};
        rem_d <= dge ? ddiff[DW-1:0] : dt[DW-1:0];
        if (cnt == '0) begin
          cnt   <= CW'(ROOT_W - 1);
          rem_s <= '0;
          root  <= '0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      frs_pkg::RP_SQRT: begin
        q <= q << 2;
        if (sge) begin
          rem_s <= sdiff[RS_W-1:0];
          root  <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem_s <= st[RS_W-1:0];
          root  <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/frs_check.sv =====
module frs_check #(
  parameter int FRAC_BITS = 16,
  localparam int SW = FRAC_BITS + 1,
  localparam int OUT_W = ((SW + frs_pkg::ACT_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  localparam logic [SW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [SW-1:0]             scale;
  logic [frs_pkg::ACT_W-1:0] action;

  assign scale  = m_tdata[SW-1:0];
  assign action = m_tdata[SW+frs_pkg::ACT_W-1:SW];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in work");

  a_action_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (action == frs_pkg::ACT_HOLD) || (action == frs_pkg::ACT_FLOOR) ||
                 (action == frs_pkg::ACT_ADJUST))
    else $error("unknown action code");

  a_scale_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (scale != '0) && (scale <= ONE))
    else $error("scale outside floor..1.0");

endmodule

bind frame_rate_resolution_scaler_core frs_check #(.FRAC_BITS(FRAC_BITS)) u_frs_check (.*);
